// ===== hw/rtl/hsc_pkg.sv =====
// Shared types, constants and position helpers for the Hamming SEC codec.
// No dependencies; used by hsc_check, hamming_sec_codec_core and the testbench.
package hsc_pkg;

  localparam int BitsW     = 63;  // width of bit-vector fields
  localparam int CountW    = 6;   // width of count fields
  localparam int MaxChecks = 6;   // parity checks of the longest codeword

  typedef enum logic {
    CmdEncode = 1'b0,
    CmdDecode = 1'b1
  } hsc_cmd_e;

  // Word in flight between stages.
  typedef struct packed {
    hsc_cmd_e          cmd;
    logic [BitsW-1:0]  word;  // bit p-1 is codeword position p
    logic [CountW-1:0] len;   // codeword length (positions 1..len)
  } hsc_word_t;

  function automatic bit is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Data index held at a non power-of-two codeword position p.
  function automatic int data_index(int p);
    int n_par;
    n_par = 0;
    for (int j = 0; j < MaxChecks; j++) begin
      if ((1 << j) <= p) n_par++;
    end
    return p - 1 - n_par;
  endfunction

  // Positions 1..n whose number has bit j set.
  function automatic logic [BitsW-1:0] cover_mask(int j, int n);
    logic [BitsW-1:0] m;
    m = '0;
    for (int p = 1; p <= BitsW; p++) begin
      if (p <= n && ((p >> j) & 1) == 1) m[p-1] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/hsc_check.sv =====
// Parity check stage: XOR trees over the covered positions of each check.
// Depends on hsc_pkg.
module hsc_check #(
  parameter int CODE_BITS = 63
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  hsc_pkg::hsc_word_t              word_i,
  output logic                            valid_o,
  output hsc_pkg::hsc_word_t              word_o,
  output logic [hsc_pkg::MaxChecks-1:0]   chk_o
);
  import hsc_pkg::*;

  logic                 valid_q;
  hsc_word_t            word_q;
  logic [MaxChecks-1:0] chk_d, chk_q;

  always_comb begin
    for (int j = 0; j < MaxChecks; j++) begin
      chk_d[j] = ^(word_i.word & cover_mask(j, CODE_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_i;
    chk_q  <= chk_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign chk_o   = chk_q;

endmodule

// ===== hw/rtl/hamming_sec_codec_core.sv =====
// Top level of the single-error-correcting Hamming codec (odd parity).
// Depends on hsc_pkg and hsc_check.
// Usage:
// - Input transaction: cmd_i, in_bits_i and in_count_i are taken at a rising
//   edge with start_i high and busy_o low. busy_o is always low: a new
//   transaction may be issued every cycle.
// - cmd_i = encode places data bits at the non power-of-two positions and
//   inserts odd parity bits; cmd_i = decode checks, corrects one flipped
//   bit and extracts the data bits.
// - Result transaction: out_valid_o is high for exactly one cycle with
//   out_bits_o / out_count_o; the receiver takes it at the edge ending
//   that cycle. The receiver cannot stall, so nothing is ever held back.
// - Register stages: the result of an accepted transaction passes three
//   register stages (input placement, parity XOR trees,
//   insert/correct/extract) before it is presented.
// - Throughput: one transaction per cycle; each stage is a fixed XOR or
//   wiring network with no feedback.
// - Reset: asynchronous, active low; clears the stage valid bits so no
//   stray result appears. The data registers are not reset.
// - CODE_BITS bounds the codeword length (3..63).
module hamming_sec_codec_core #(
  parameter int CODE_BITS = 63
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [hsc_pkg::BitsW-1:0]    in_bits_i,
  input  logic [hsc_pkg::CountW-1:0]   in_count_i,
  output logic                         out_valid_o,
  output logic [hsc_pkg::BitsW-1:0]    out_bits_o,
  output logic [hsc_pkg::CountW-1:0]   out_count_o
);
  import hsc_pkg::*;

  // Parity positions up to CODE_BITS and data capacity of the codeword.
  localparam int Checks  = $clog2(CODE_BITS + 1);
  localparam int DataCap = CODE_BITS - Checks;
  localparam logic [CountW-1:0] DataCapC = CountW'(DataCap);
  localparam logic [CountW-1:0] CodeLenC = CountW'(CODE_BITS);

  // Codeword length for n data bits: n plus parity bits needed.
  function automatic logic [CountW-1:0] enc_last(logic [CountW-1:0] n);
    logic [CountW-1:0] r;
    r = '0;
    for (int k = 0; k < Checks; k++) begin
      if (CountW'((1 << k) - k - 1) < n) r = r + 1'b1;
    end
    return n + r;
  endfunction

  // Number of parity positions at or below len.
  function automatic logic [CountW-1:0] n_par(logic [CountW-1:0] len);
    logic [CountW-1:0] r;
    r = '0;
    for (int j = 0; j < MaxChecks; j++) begin
      if ((CountW+1)'(1 << j) <= {1'b0, len}) r = r + 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stage 1: saturate counts, mask unused bits, place data bits.
  // ---------------------------------------------------------------------
  logic              accept;
  logic [CountW-1:0] n_enc, n_dec;
  logic [BitsW-1:0]  enc_word, dec_word;
  hsc_word_t         s1_d, s1_q;
  logic              s1_valid_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    n_enc    = (in_count_i > DataCapC) ? DataCapC : in_count_i;
    n_dec    = (in_count_i > CodeLenC) ? CodeLenC : in_count_i;
    enc_word = '0;
    dec_word = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (!is_pow2(p)) begin
        enc_word[p-1] = in_bits_i[data_index(p)] & (CountW'(data_index(p)) < n_enc);
      end
      dec_word[p-1] = in_bits_i[p-1] & (CountW'(p - 1) < n_dec);
    end
    s1_d.cmd = hsc_cmd_e'(cmd_i);
    if (hsc_cmd_e'(cmd_i) == CmdEncode) begin
      s1_d.word = enc_word;
      s1_d.len  = enc_last(n_enc);
    end else begin
      s1_d.word = dec_word;
      s1_d.len  = n_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------
  // Stage 2: parity check XOR trees.
  // ---------------------------------------------------------------------
  logic                 s2_valid;
  hsc_word_t            s2_word;
  logic [MaxChecks-1:0] s2_chk;

  hsc_check #(
    .CODE_BITS(CODE_BITS)
  ) u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid_q),
    .word_i (s1_q),
    .valid_o(s2_valid),
    .word_o (s2_word),
    .chk_o  (s2_chk)
  );

  // ---------------------------------------------------------------------
  // Stage 3: insert parity (encode) or correct and extract (decode).
  // ---------------------------------------------------------------------
  logic [BitsW-1:0]  enc_out, fix_word, dec_out, out_bits_d, out_bits_q;
  logic [CountW-1:0] err_pos, out_count_d, out_count_q;
  logic              out_valid_q;

  always_comb begin
    enc_out  = s2_word.word;
    fix_word = s2_word.word;
    err_pos  = '0;
    dec_out  = '0;
    for (int j = 0; j < MaxChecks; j++) begin
      if ((CountW+1)'(1 << j) <= {1'b0, s2_word.len}) begin
        enc_out[(1 << j) - 1] = ~s2_chk[j];   // odd parity
        err_pos[j]            = ~s2_chk[j];   // failed check
      end
    end
    // flip only a position inside the word
    if (err_pos != '0 && err_pos <= s2_word.len) begin
      fix_word[err_pos - 1'b1] = ~fix_word[err_pos - 1'b1];
    end
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (!is_pow2(p)) dec_out[data_index(p)] = fix_word[p-1];
    end
    if (s2_word.cmd == CmdEncode) begin
      out_bits_d  = enc_out;
      out_count_d = s2_word.len;
    end else begin
      out_bits_d  = dec_out;
      out_count_d = s2_word.len - n_par(s2_word.len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bits_q  <= out_bits_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_bits_o  = out_bits_q;
  assign out_count_o = out_count_q;

`ifndef NO_ASSERTIONS
  // Every accepted transaction yields its result on out_valid_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 out_valid_o)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##3 out_valid_o |-> $past(accept, 3))
    else $error("result without matching transaction");

  // Result length never exceeds the codeword bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_count_o <= CodeLenC)
    else $error("result count beyond codeword length");

  // Bits at and above the result count are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_bits_o >> out_count_o) == '0)
    else $error("result bits set beyond result count");
`endif

endmodule

// ===== tb/hsc_codec_calc_pkg.sv =====
// Bit-exact encode and decode calculations for the Hamming SEC codec.
// Depends on hsc_pkg; used by hsc_codec_checker and tb_hamming_sec_codec_core.
`timescale 1ns / 1ps
package hsc_codec_calc_pkg;

  import hsc_pkg::*;

  // Power-of-two positions carry check bits.
  function automatic bit is_check_pos(int unsigned p);
    return $countones(p) == 1;
  endfunction

  // Data bits go to non check positions.
  // Odd parity: check bit at 2^j = 1 ^ (XOR of covered positions).
  // Data counts beyond what fits in the word saturate.
  function automatic void sec_encode(input  logic [BitsW-1:0]  data,
                                     input  int unsigned       n_data,
                                     output logic [BitsW-1:0]  cw,
                                     output logic [CountW-1:0] len);
    int unsigned used, last, pos, c;
    bit          par;
    cw   = '0;
    used = 0;
    last = 0;
    for (pos = 1; pos <= BitsW; pos++) begin
      if (used < n_data && !is_check_pos(pos)) begin
        cw[pos-1] = data[used];
        last      = pos;
        used++;
      end
    end
    for (c = 1; c <= last; c = c * 2) begin
      par = 1'b1;
      for (pos = 1; pos <= last; pos++) begin
        if ((pos & c) != 0) par ^= cw[pos-1];
      end
      cw[c-1] = par;
    end
    len = CountW'(last);
  endfunction

  // Failing checks form the error position; flip it if it lies in the word,
  // then pull out the data positions.
  function automatic void sec_decode(input  logic [BitsW-1:0]  word_in,
                                     input  int unsigned       n_in,
                                     output logic [BitsW-1:0]  data,
                                     output logic [CountW-1:0] len);
    logic [BitsW-1:0] w;
    int unsigned      n, syn, k, p, c;
    bit               par;
    n    = (n_in > BitsW) ? BitsW : n_in;
    w    = '0;
    data = '0;
    syn  = 0;
    k    = 0;
    for (p = 1; p <= n; p++) w[p-1] = word_in[p-1];
    for (c = 1; c <= n; c = c * 2) begin
      par = 1'b0;
      for (p = 1; p <= n; p++) begin
        if ((p & c) != 0) par ^= w[p-1];
      end
      if (!par) syn |= c;
    end
    if (syn >= 1 && syn <= n) w[syn-1] = ~w[syn-1];
    for (p = 1; p <= n; p++) begin
      if (!is_check_pos(p)) begin
        data[k] = w[p-1];
        k++;
      end
    end
    len = CountW'(k);
  endfunction

endpackage

// ===== tb/hsc_codec_checker.sv =====
// Scoreboard for hamming_sec_codec_core: predicts each result and compares.
// Depends on hsc_pkg and hsc_codec_calc_pkg.
`timescale 1ns / 1ps
module hsc_codec_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       cmd_i,
  input  logic [hsc_pkg::BitsW-1:0]  in_bits_i,
  input  logic [hsc_pkg::CountW-1:0] in_count_i,
  input  logic                       out_valid_i,
  input  logic [hsc_pkg::BitsW-1:0]  out_bits_i,
  input  logic [hsc_pkg::CountW-1:0] out_count_i,
  output int                         err_count_o,
  output int                         pending_o
);
  import hsc_pkg::*;
  import hsc_codec_calc_pkg::*;

  typedef struct {
    hsc_cmd_e          cmd;
    logic [BitsW-1:0]  src_bits;
    logic [CountW-1:0] src_count;
    logic [BitsW-1:0]  bits;
    logic [CountW-1:0] count;
  } codec_result_t;

  codec_result_t expected_results_q[$];
  int            mismatches = 0;

  always @(posedge clk_i) begin : score
    codec_result_t want;
    if (rst_ni) begin
      // results first, so a new transaction can never satisfy a stray strobe
      if (out_valid_i) begin
        if (expected_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual bits %h count %0d",
                   $time, out_bits_i, out_count_i);
        end else begin
          want = expected_results_q.pop_front();
          if (out_bits_i !== want.bits) begin
            mismatches++;
            $display("%0t: out_bits (%s in %h/%0d): expected %h, actual %h", $time,
                     want.cmd.name(), want.src_bits, want.src_count, want.bits, out_bits_i);
          end
          if (out_count_i !== want.count) begin
            mismatches++;
            $display("%0t: out_count (%s in %h/%0d): expected %0d, actual %0d", $time,
                     want.cmd.name(), want.src_bits, want.src_count, want.count,
                     out_count_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        want.cmd       = hsc_cmd_e'(cmd_i);
        want.src_bits  = in_bits_i;
        want.src_count = in_count_i;
        if (want.cmd == CmdEncode) begin
          sec_encode(in_bits_i, 32'(in_count_i), want.bits, want.count);
        end else begin
          sec_decode(in_bits_i, 32'(in_count_i), want.bits, want.count);
        end
        expected_results_q = {expected_results_q, want};
      end
    end
    err_count_o <= mismatches;
    pending_o   <= expected_results_q.size();
  end

endmodule

// ===== tb/tb_hamming_sec_codec_core.sv =====
// Stimulus and verdict for hamming_sec_codec_core: directed corners, then
// random encode/decode traffic, over half codewords, most with zero to two flips.
// Depends on hsc_pkg, hsc_codec_calc_pkg and hsc_codec_checker.
`timescale 1ns / 1ps
module tb_hamming_sec_codec_core;

  import hsc_pkg::*;
  import hsc_codec_calc_pkg::*;

  localparam int NumRandom     = 450;
  localparam int WatchdogLimit = 500;  // above the longest sender gap from next_gap
  localparam int DrainCycles   = 8;    // three-stage pipeline plus margin

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  hsc_cmd_e          cmd;
  logic [BitsW-1:0]  in_bits;
  logic [CountW-1:0] in_count;
  logic              out_valid;
  logic [BitsW-1:0]  out_bits;
  logic [CountW-1:0] out_count;

  int   err_count;
  int   pending;
  logic took_q      = 1'b0;  // a transaction was taken at the last rising edge
  int   idle_cycles = 0;
  int   issued      = 0;

  hamming_sec_codec_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .in_bits_i  (in_bits),
    .in_count_i (in_count),
    .out_valid_o(out_valid),
    .out_bits_o (out_bits),
    .out_count_o(out_count)
  );

  hsc_codec_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .cmd_i      (cmd),
    .in_bits_i  (in_bits),
    .in_count_i (in_count),
    .out_valid_i(out_valid),
    .out_bits_i (out_bits),
    .out_count_i(out_count),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) took_q <= start && !busy;

  // Watchdog: reset or any accepted transaction on either side clears the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [BitsW-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[BitsW-1:0];
  endfunction

  // Mostly short gaps, a few long ones; every 64 transactions a stretch
  // of 16 back-to-back.
  function automatic int next_gap();
    int r;
    if ((issued % 64) < 16) return 0;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic issue(input hsc_cmd_e op, input logic [BitsW-1:0] bits,
                       input int unsigned cnt);
    int gap;
    start    <= 1'b1;
    cmd      <= op;
    in_bits  <= bits;
    in_count <= CountW'(cnt);
    do @(negedge clk); while (!took_q);
    issued++;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Encode locally, corrupt, optionally stretch the count, fill junk above it.
  task automatic issue_codeword(input logic [BitsW-1:0] data, input int unsigned n_data,
                                input logic [BitsW-1:0] flips, input int unsigned extra,
                                input bit junk);
    logic [BitsW-1:0]  cw;
    logic [CountW-1:0] len;
    int unsigned       cnt;
    sec_encode(data, n_data, cw, len);
    cnt = len + extra;
    if (cnt > BitsW) cnt = BitsW;
    cw ^= flips;
    if (junk) cw |= rand_word() & ~({BitsW{1'b1}} >> (BitsW - cnt));
    issue(CmdDecode, cw, cnt);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [BitsW-1:0]  ones;
    logic [BitsW-1:0]  cw;
    logic [BitsW-1:0]  flips;
    logic [CountW-1:0] len;
    int unsigned       n_data;
    int                pick;
    ones     = '1;
    rst_n    = 1'b0;
    start    = 1'b0;
    cmd      = CmdEncode;
    in_bits  = '0;
    in_count = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty input, single bits, full and saturated encodes
    issue(CmdEncode, '0, 0);
    issue(CmdEncode, ones, 0);
    issue(CmdEncode, 63'h1, 1);
    issue(CmdEncode, '0, 1);
    issue(CmdEncode, 63'hb, 4);
    issue(CmdEncode, ones, 57);
    issue(CmdEncode, '0, 57);
    issue(CmdEncode, ones, 58);
    issue(CmdEncode, rand_word(), 63);
    issue(CmdEncode, ones, 11);               // bits beyond the count ignored
    // directed decodes: empty, tiny words, full width
    issue(CmdDecode, ones, 0);
    issue(CmdDecode, 63'h1, 1);
    issue(CmdDecode, '0, 1);
    issue(CmdDecode, '0, 2);
    issue(CmdDecode, ones, 3);
    issue(CmdDecode, ones, 63);
    issue(CmdDecode, '0, 63);
    // clean codeword, then single flips on first, last and a data position
    issue_codeword(ones, 57, '0, 0, 1'b0);
    issue_codeword(rand_word(), 57, 63'h1, 0, 1'b0);
    issue_codeword(rand_word(), 57, 63'h1 << 62, 0, 1'b0);
    issue_codeword(rand_word(), 57, 63'h4, 0, 1'b0);
    issue_codeword(63'h5, 4, 63'h21, 0, 1'b0);        // double flip
    issue_codeword(63'h1a, 5, '0, 2, 1'b1);           // count past the word
    issue_codeword(rand_word(), 26, 63'h1 << 15, 0, 1'b1);
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 150 || i == 320) wait_drained();
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        n_data = ($urandom_range(9, 0) == 0) ? $urandom_range(63, 50) : $urandom_range(57, 0);
        sec_encode('0, n_data, cw, len);      // only len is needed here
        flips = '0;
        pick  = $urandom_range(99, 0);
        if (len > 0) begin
          if (pick >= 25 && pick < 75) begin
            flips = 63'h1 << $urandom_range(len - 1, 0);
          end else if (pick >= 75 && pick < 90) begin
            flips = (63'h1 << $urandom_range(len - 1, 0)) ^
                    (63'h1 << $urandom_range(len - 1, 0));
          end else if (pick >= 90) begin
            flips = rand_word();
          end
        end
        issue_codeword(rand_word(), n_data, flips,
                       ($urandom_range(9, 0) == 0) ? $urandom_range(5, 1) : 0,
                       1'($urandom_range(1, 0)));
      end else if (pick < 80) begin
        issue(CmdEncode, rand_word(), $urandom_range(63, 0));
      end else begin
        issue(CmdDecode, rand_word(), $urandom_range(63, 0));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== hamming_sec_codec_core.f =====
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_check.sv
hw/rtl/hamming_sec_codec_core.sv
tb/hsc_codec_calc_pkg.sv
tb/hsc_codec_checker.sv
tb/tb_hamming_sec_codec_core.sv
